// ===== design/llmc_pkg.sv =====
// Package: shared widths, constants and exp tables for the mixture classifier.
`timescale 1ns / 1ps
package llmc_pkg;
    localparam int MaxInputs     = 4;
    localparam int MaxClasses    = 4;
    localparam int MaxComponents = 4;
    localparam int MaxFeatures   = 1 + MaxInputs * (MaxInputs + 3) / 2;
    localparam int MaxUnits      = MaxClasses * MaxComponents;
    localparam int WeightDepth   = MaxFeatures * MaxUnits;
    localparam int WaddrW        = $clog2(WeightDepth);
    localparam int FeatW         = $clog2(MaxFeatures);
    localparam int UnitW         = $clog2(MaxUnits);

    localparam logic [1:0] CfgInputCount     = 2'd0;
    localparam logic [1:0] CfgClassCount     = 2'd1;
    localparam logic [1:0] CfgComponentCount = 2'd2;

    // round(65536 * exp(-k))
    function automatic logic [16:0] int_exp(input logic [3:0] k);
        logic [16:0] v;
        begin
            case (k)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd24109;
                4'd2:    v = 17'd8869;
                4'd3:    v = 17'd3263;
                4'd4:    v = 17'd1200;
                4'd5:    v = 17'd442;
                4'd6:    v = 17'd162;
                4'd7:    v = 17'd60;
                4'd8:    v = 17'd22;
                4'd9:    v = 17'd8;
                4'd10:   v = 17'd3;
                4'd11:   v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

    // round(65536 * exp(-j/16))
    function automatic logic [16:0] frac_exp(input logic [3:0] j);
        logic [16:0] v;
        begin
            case (j)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd61565;
                4'd2:    v = 17'd57835;
                4'd3:    v = 17'd54331;
                4'd4:    v = 17'd51039;
                4'd5:    v = 17'd47947;
                4'd6:    v = 17'd45042;
                4'd7:    v = 17'd42313;
                4'd8:    v = 17'd39750;
                4'd9:    v = 17'd37341;
                4'd10:   v = 17'd35079;
                4'd11:   v = 17'd32954;
                4'd12:   v = 17'd30957;
                4'd13:   v = 17'd29081;
                4'd14:   v = 17'd27319;
                default: v = 17'd25664;
            endcase
            return v;
        end
    endfunction
endpackage

// ===== design/llmc_divider.sv =====
// Radix-2 restoring divider: quotient of a 33-bit numerator by a 21-bit divisor.
`timescale 1ns / 1ps
module llmc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] numer,
    input  logic [20:0] denom,
    output logic        done,
    output logic [32:0] quot
);
    logic [32:0] quot_reg, quot_next;
    logic [21:0] rem_reg, rem_next;
    logic [20:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [21:0] trial;

    // one quotient bit per cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[20:0], quot_reg[32]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !start) |=> !busy_reg) else $error("divider started itself");
endmodule

// ===== design/log_linear_mixture_classifier.sv =====
// Top level: mixture classifier, one shared multiply-accumulate under a sequencer.
// Sequence: weight writes and non-last elements are taken while idle. A last element runs
// feature expansion, unit sums (each MAC a weight read, then an accumulate, plus a
// unit-end step per unit), a max search over the units, an exp per unit, a divide per unit
// on the shared divider and an emit per class.
// Input stalls until the last result is taken; reset clears control state, registers to 4.
`timescale 1ns / 1ps
module log_linear_mixture_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  feature_index,
    input  logic [1:0]  class_index,
    input  logic [1:0]  component_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] sample_value,
    input  logic        sample_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  class_number,
    output logic [15:0] posterior,
    output logic        last_class,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_FEAT, S_MAC_RD, S_MAC, S_UNIT_END, S_MAX, S_EXP1, S_EXP2,
        S_DIV_GO, S_DIV_WAIT, S_EMIT, S_OUT
    } state_t;

    localparam int SpW = $clog2(llmc_pkg::MaxInputs + 1);
    localparam int IdxW = $clog2(llmc_pkg::MaxInputs);

    state_t state_reg;
    logic [2:0] n_cfg_reg, c_cfg_reg, m_cfg_reg;
    logic [SpW-1:0] pos_reg;

    logic signed [15:0] wmem [llmc_pkg::WeightDepth];
    logic signed [15:0] wrd_reg;
    logic signed [15:0] smp [llmc_pkg::MaxInputs];
    logic signed [15:0] feat [llmc_pkg::MaxFeatures];
    logic signed [31:0] act [llmc_pkg::MaxUnits];
    logic [16:0] ex [llmc_pkg::MaxUnits];

    // clamped configuration
    logic [2:0] n_eff, c_eff, m_eff;
    logic [llmc_pkg::FeatW:0] nf;
    always_comb
    begin
        n_eff = (n_cfg_reg == 3'd0) ? 3'd1 :
                (n_cfg_reg > 3'(llmc_pkg::MaxInputs)) ? 3'(llmc_pkg::MaxInputs) : n_cfg_reg;
        c_eff = (c_cfg_reg == 3'd0) ? 3'd1 :
                (c_cfg_reg > 3'(llmc_pkg::MaxClasses)) ? 3'(llmc_pkg::MaxClasses) : c_cfg_reg;
        m_eff = (m_cfg_reg == 3'd0) ? 3'd1 :
                (m_cfg_reg > 3'(llmc_pkg::MaxComponents)) ?
                    3'(llmc_pkg::MaxComponents) : m_cfg_reg;
        nf = (llmc_pkg::FeatW+1)'(1 + ((32'(n_eff) * (32'(n_eff) + 3)) >> 1));
    end

    // sequencer counters
    logic [llmc_pkg::FeatW-1:0] f_reg;
    logic [IdxW-1:0] fi_reg, fj_reg;
    logic [1:0] k_reg, m_reg;
    logic signed [47:0] acc_reg;
    logic signed [31:0] amax_reg;
    logic [20:0] tot_reg;
    logic [17:0] post_reg;
    logic [16:0] e1_reg;
    logic [7:0]  rr_reg;
    logic [3:0]  kk_reg;
    logic [1:0]  onum_reg;
    logic [15:0] opost_reg;
    logic        olast_reg;

    logic [llmc_pkg::UnitW-1:0] unit;
    assign unit = llmc_pkg::UnitW'({k_reg, m_reg});

    logic in_acc, cfg_acc, last_el;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign last_el   = in_acc && req_type && sample_last;

    // shared multiplier operands
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;
    logic signed [32:0] prnd;
    logic signed [15:0] psat;
    always_comb
    begin
        mul_a = smp[fi_reg];
        mul_b = smp[fj_reg];
        if (state_reg == S_MAC)
        begin
            mul_a = feat[f_reg];
            mul_b = wrd_reg;
        end
        prod = mul_a * mul_b;
        prnd = (33'(prod) + 33'sd2048) >>> 12;
        psat = (prnd > 33'sd32767) ? 16'sd32767 :
               (prnd < -33'sd32768) ? -16'sd32768 : 16'(prnd);
    end

    // accumulator rounding
    logic signed [47:0] arnd;
    logic signed [31:0] asat;
    logic zeroed;
    always_comb
    begin
        arnd = (acc_reg + 48'sd2048) >>> 12;
        asat = (arnd > 48'sd2147483647) ? 32'h7fffffff :
               (arnd < -48'sd2147483648) ? 32'h80000000 : 32'(arnd);
        zeroed = (3'(k_reg) == c_eff - 3'd1) && (3'(m_reg) == m_eff - 3'd1);
    end

    // exp argument
    logic [32:0] tdiff;
    logic [33:0] e_prod1;
    logic [33:0] e_prod2;
    always_comb
    begin
        tdiff   = 33'(34'(amax_reg) - 34'(act[unit]));
        e_prod1 = 34'(llmc_pkg::int_exp(tdiff[15:12])) *
                  34'(llmc_pkg::frac_exp(tdiff[11:8]));
        e_prod2 = 34'(e1_reg) * 34'(17'd65536 - {5'd0, rr_reg, 4'd0});
    end

    // divider
    logic        div_start, div_done;
    logic [32:0] div_q;
    assign div_start = (state_reg == S_DIV_GO);
    llmc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({ex[unit], 16'd0} + 33'(tot_reg >> 1)),
        .denom (tot_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    logic [IdxW-1:0] wpos;
    assign wpos = IdxW'(pos_reg);

    // weight memory
    always_ff @(posedge clk)
    begin
        if (in_acc && !req_type && feature_index < 4'(llmc_pkg::MaxFeatures))
            wmem[llmc_pkg::WaddrW'({feature_index, class_index, component_index})]
                <= weight_value;
        wrd_reg <= wmem[llmc_pkg::WaddrW'({f_reg, k_reg, m_reg})];
    end

    // control state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_cfg_reg <= 3'd4;
            c_cfg_reg <= 3'd4;
            m_cfg_reg <= 3'd4;
            pos_reg   <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    llmc_pkg::CfgInputCount:     n_cfg_reg <= cfg_data;
                    llmc_pkg::CfgClassCount:     c_cfg_reg <= cfg_data;
                    llmc_pkg::CfgComponentCount: m_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && req_type)
                    begin
                        if (sample_last)
                        begin
                            pos_reg   <= '0;
                            state_reg <= S_FEAT;
                        end
                        else if (3'(pos_reg) < n_eff)
                            pos_reg <= pos_reg + SpW'(1);
                    end
                end
                S_FEAT:
                    if (32'(f_reg) + 1 >= 32'(nf)) state_reg <= S_MAC_RD;
                S_MAC_RD: state_reg <= zeroed ? S_UNIT_END : S_MAC;
                S_MAC:
                    if (32'(f_reg) + 1 >= 32'(nf)) state_reg <= S_UNIT_END;
                    else state_reg <= S_MAC_RD;
                S_UNIT_END:
                begin
                    if (3'(m_reg) + 3'd1 < m_eff) state_reg <= S_MAC_RD;
                    else if (3'(k_reg) + 3'd1 < c_eff) state_reg <= S_MAC_RD;
                    else state_reg <= S_MAX;
                end
                S_MAX:
                    if (3'(m_reg) + 3'd1 >= m_eff && 3'(k_reg) + 3'd1 >= c_eff)
                        state_reg <= S_EXP1;
                S_EXP1: state_reg <= S_EXP2;
                S_EXP2:
                    if (3'(m_reg) + 3'd1 >= m_eff && 3'(k_reg) + 3'd1 >= c_eff)
                        state_reg <= S_DIV_GO;
                    else state_reg <= S_EXP1;
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                    if (div_done)
                    begin
                        if (3'(m_reg) + 3'd1 >= m_eff) state_reg <= S_EMIT;
                        else state_reg <= S_DIV_GO;
                    end
                S_EMIT: state_reg <= S_OUT;
                S_OUT:
                    if (!out_stall)
                    begin
                        if (olast_reg) state_reg <= S_IDLE;
                        else state_reg <= S_DIV_GO;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && req_type && 3'(pos_reg) < n_eff)
                    smp[wpos] <= sample_value;
                f_reg  <= '0;
                fi_reg <= '0;
                fj_reg <= '0;
                k_reg  <= '0;
                m_reg  <= '0;
                acc_reg <= '0;
            end
            S_FEAT:
            begin
                // bias, inputs, then products j outer, i inner
                if (f_reg == '0)
                    feat[0] <= 16'sd4096;
                else if (32'(f_reg) <= 32'(n_eff))
                    feat[f_reg] <= smp[IdxW'(f_reg - 1'b1)];
                else
                begin
                    feat[f_reg] <= psat;
                    if (3'(fi_reg) + 3'd1 < n_eff)
                        fi_reg <= fi_reg + 1'b1;
                    else
                    begin
                        fj_reg <= fj_reg + 1'b1;
                        fi_reg <= fj_reg + 1'b1;
                    end
                end
                if (32'(f_reg) + 1 >= 32'(nf)) f_reg <= '0;
                else f_reg <= f_reg + 1'b1;
            end
            S_MAC:
            begin
                acc_reg <= acc_reg + 48'(prod);
                if (32'(f_reg) + 1 >= 32'(nf)) f_reg <= '0;
                else f_reg <= f_reg + 1'b1;
            end
            S_UNIT_END:
            begin
                act[unit] <= asat;
                acc_reg   <= '0;
                f_reg     <= '0;
                if (3'(m_reg) + 3'd1 < m_eff) m_reg <= m_reg + 1'b1;
                else
                begin
                    m_reg <= '0;
                    if (3'(k_reg) + 3'd1 < c_eff) k_reg <= k_reg + 1'b1;
                    else k_reg <= '0;
                end
                amax_reg <= (unit == '0) ? asat : act[0];
            end
            S_MAX:
            begin
                if (act[unit] > amax_reg) amax_reg <= act[unit];
                tot_reg <= '0;
                if (3'(m_reg) + 3'd1 < m_eff) m_reg <= m_reg + 1'b1;
                else
                begin
                    m_reg <= '0;
                    if (3'(k_reg) + 3'd1 < c_eff) k_reg <= k_reg + 1'b1;
                    else k_reg <= '0;
                end
            end
            S_EXP1:
            begin
                kk_reg <= (tdiff[32:12] >= 21'd12) ? 4'd12 : tdiff[15:12];
                rr_reg <= tdiff[7:0];
                e1_reg <= 17'((e_prod1 + 34'd32768) >> 16);
            end
            S_EXP2:
            begin
                ex[unit] <= (kk_reg == 4'd12) ? 17'd0 : 17'((e_prod2 + 34'd32768) >> 16);
                tot_reg  <= tot_reg + ((kk_reg == 4'd12) ? 21'd0 :
                            21'((e_prod2 + 34'd32768) >> 16));
                post_reg <= '0;
                if (3'(m_reg) + 3'd1 < m_eff) m_reg <= m_reg + 1'b1;
                else
                begin
                    m_reg <= '0;
                    if (3'(k_reg) + 3'd1 < c_eff) k_reg <= k_reg + 1'b1;
                    else k_reg <= '0;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    post_reg <= post_reg + 18'(div_q);
                    if (3'(m_reg) + 3'd1 < m_eff) m_reg <= m_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                onum_reg  <= k_reg;
                opost_reg <= (post_reg > 18'd65535) ? 16'hffff : post_reg[15:0];
                olast_reg <= (3'(k_reg) == c_eff - 3'd1);
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    m_reg    <= '0;
                    k_reg    <= k_reg + 1'b1;
                    post_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = (state_reg == S_OUT);
    assign class_number = onum_reg;
    assign posterior    = opost_reg;
    assign last_class   = olast_reg;

    a_busy_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cfg_ready) else $error("config open while busy");
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        last_el |=> (state_reg == S_FEAT)) else $error("last element did not start");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= llmc_pkg::MaxInputs) else $error("sample position overflow");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_class) |=> (state_reg == S_IDLE))
        else $error("did not finish after last class");
endmodule

// ===== tb/llmc_checker.sv =====
// Checker: watches the mixture classifier channels, predicts posteriors and compares results.
`timescale 1ns / 1ps
module llmc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  feature_index,
    input  logic [1:0]  class_index,
    input  logic [1:0]  component_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] sample_value,
    input  logic        sample_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  class_number,
    input  logic [15:0] posterior,
    input  logic        last_class,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    // predictor copy of the block state
    logic [2:0] num_inputs_reg;
    logic [2:0] num_classes_reg;
    logic [2:0] num_comps_reg;
    logic signed [15:0] weight_mem [llmc_pkg::WeightDepth];
    logic signed [15:0] sample_mem [llmc_pkg::MaxInputs];
    int unsigned fill_pos;

    // expected posteriors, oldest first
    logic [1:0]  want_class [$];
    logic [15:0] want_post [$];
    logic        want_last [$];

    longint unsigned whole_exp [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                        22, 8, 3, 1};
    longint unsigned part_exp [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                       42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                       27319, 25664};

    function automatic int unsigned clamp_count(logic [2:0] v, int unsigned hi);
        if (v == 3'd0)
            return 1;
        return (v > hi) ? hi : int'(v);
    endfunction

    // round Q.24 to Q.12 (floor shift)
    function automatic longint round_q12(longint v);
        return (v + 64'sd2048) >>> 12;
    endfunction

    // exp(-t) in Q1.16 by table lookup plus linear correction
    function automatic longint unsigned exp_neg(longint t);
        longint unsigned k, j, r, e;
        if (t < 0)
            t = 0;
        k = t >> 12;
        if (k >= 12)
            return 0;
        j = (t >> 8) & 15;
        r = t & 255;
        e = (whole_exp[k] * part_exp[j] + 32768) >> 16;
        e = (e * (65536 - 16 * r) + 32768) >> 16;
        return e;
    endfunction

    // full classification of the stored sample
    task automatic predict_posteriors();
        int unsigned n, nc, nm, nf, f, u;
        longint feat [llmc_pkg::MaxFeatures];
        longint act [llmc_pkg::MaxUnits];
        longint unsigned ex [llmc_pkg::MaxUnits];
        longint unsigned total, post;
        longint acc, amax, p;
        n  = clamp_count(num_inputs_reg, llmc_pkg::MaxInputs);
        nc = clamp_count(num_classes_reg, llmc_pkg::MaxClasses);
        nm = clamp_count(num_comps_reg, llmc_pkg::MaxComponents);
        nf = 1 + n * (n + 3) / 2;
        // quadratic feature expansion
        feat[0] = 4096;
        for (int i = 0; i < n; i++)
            feat[i + 1] = sample_mem[i];
        f = n + 1;
        for (int j = 0; j < n; j++)
        begin
            for (int i = j; i < n; i++)
            begin
                p = round_q12(longint'(sample_mem[i]) * longint'(sample_mem[j]));
                if (p > 32767)
                    p = 32767;
                if (p < -32768)
                    p = -32768;
                feat[f] = p;
                f++;
            end
        end
        // unit sums; last unit of last class is forced to zero weight
        for (int k = 0; k < nc; k++)
        begin
            for (int m = 0; m < nm; m++)
            begin
                acc = 0;
                if (!(k == nc - 1 && m == nm - 1))
                    for (int h = 0; h < nf; h++)
                        acc += feat[h] * longint'(weight_mem[(h * llmc_pkg::MaxClasses + k)
                                                  * llmc_pkg::MaxComponents + m]);
                acc = round_q12(acc);
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                act[k * llmc_pkg::MaxComponents + m] = acc;
            end
        end
        // softmax with maximum subtracted
        amax = act[0];
        for (int k = 0; k < nc; k++)
            for (int m = 0; m < nm; m++)
                if (act[k * llmc_pkg::MaxComponents + m] > amax)
                    amax = act[k * llmc_pkg::MaxComponents + m];
        total = 0;
        for (int k = 0; k < nc; k++)
        begin
            for (int m = 0; m < nm; m++)
            begin
                u = k * llmc_pkg::MaxComponents + m;
                ex[u] = exp_neg(amax - act[u]);
                total += ex[u];
            end
        end
        if (total == 0)
            total = 1;
        for (int k = 0; k < nc; k++)
        begin
            post = 0;
            for (int m = 0; m < nm; m++)
                post += (ex[k * llmc_pkg::MaxComponents + m] * 65536 + total / 2) / total;
            if (post > 65535)
                post = 65535;
            want_class.push_back(k[1:0]);
            want_post.push_back(post[15:0]);
            want_last.push_back(k == nc - 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_inputs_reg  = 3'd4;
            num_classes_reg = 3'd4;
            num_comps_reg   = 3'd4;
            fill_pos        = 0;
            fail_count      = 0;
            pending         = 0;
        end
        else
        begin
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == llmc_pkg::CfgInputCount)
                    num_inputs_reg = cfg_data;
                else if (cfg_index == llmc_pkg::CfgClassCount)
                    num_classes_reg = cfg_data;
                else if (cfg_index == llmc_pkg::CfgComponentCount)
                    num_comps_reg = cfg_data;
            end
            // input transaction
            if (in_valid && !in_stall)
            begin
                if (!req_type)
                begin
                    if (feature_index < llmc_pkg::MaxFeatures)
                        weight_mem[(int'(feature_index) * llmc_pkg::MaxClasses
                                    + int'(class_index)) * llmc_pkg::MaxComponents
                                   + int'(component_index)] = weight_value;
                end
                else
                begin
                    if (fill_pos < clamp_count(num_inputs_reg, llmc_pkg::MaxInputs))
                    begin
                        sample_mem[fill_pos] = sample_value;
                        if (!sample_last)
                            fill_pos++;
                    end
                    if (sample_last)
                    begin
                        fill_pos = 0;
                        predict_posteriors();
                    end
                end
            end
            // result transaction
            if (out_valid && !out_stall)
            begin
                if (want_post.size() == 0)
                begin
                    $error("unexpected result: class_number=%0d posterior=%0d",
                           class_number, posterior);
                    fail_count++;
                end
                else
                begin
                    if (class_number !== want_class[0])
                    begin
                        $error("class_number: expected %0d, got %0d",
                               want_class[0], class_number);
                        fail_count++;
                    end
                    if (posterior !== want_post[0])
                    begin
                        $error("posterior: expected %0d, got %0d", want_post[0], posterior);
                        fail_count++;
                    end
                    if (last_class !== want_last[0])
                    begin
                        $error("last_class: expected %0d, got %0d", want_last[0], last_class);
                        fail_count++;
                    end
                    void'(want_class.pop_front());
                    void'(want_post.pop_front());
                    void'(want_last.pop_front());
                end
            end
            pending = want_post.size();
        end
    end

endmodule

// ===== tb/log_linear_mixture_classifier_tb.sv =====
// Testbench top: stimulus, back-pressure, clock/reset and verdict for the mixture classifier.
`timescale 1ns / 1ps
module log_linear_mixture_classifier_tb;

    localparam int CycleLimit = 1_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic [3:0] feature_index = '0;
    logic [1:0] class_index = '0;
    logic [1:0] component_index = '0;
    logic signed [15:0] weight_value = '0;
    logic signed [15:0] sample_value = '0;
    logic sample_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] class_number;
    logic [15:0] posterior;
    logic last_class;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;
    int fail_count;
    int pending;
    int cycles = 0;
    int stall_mode = 0;

    log_linear_mixture_classifier i_dut (.*);

    llmc_checker i_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("** log_linear_mixture_classifier: FAILED **");
            $finish;
        end
    end

    // result back-pressure: quiet, light or heavy stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= int'($urandom_range(0, 2));
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [15:0] rand_sample();
        int r;
        r = int'($urandom_range(0, 7));
        if (r == 0)
            return 16'($urandom);
        if (r == 1)
            return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    function automatic logic [15:0] rand_weight();
        if ($urandom_range(0, 5) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    // one input transaction, with a random gap ahead of it
    task automatic send_item(logic rt, logic [3:0] fi, logic [1:0] ci, logic [1:0] mi,
                             logic [15:0] wv, logic [15:0] sv, logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= rt;
        feature_index   <= fi;
        class_index     <= ci;
        component_index <= mi;
        weight_value    <= wv;
        sample_value    <= sv;
        sample_last     <= lst;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_weight(logic [3:0] fi, logic [1:0] ci, logic [1:0] mi,
                                logic [15:0] wv);
        send_item(1'b0, fi, ci, mi, wv, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_element(logic [15:0] sv, logic lst);
        send_item(1'b1, 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom), sv, lst);
    endtask

    task automatic send_sample(int len);
        for (int i = 0; i < len - 1; i++)
            send_element(rand_sample(), 1'b0);
        send_element(rand_sample(), 1'b1);
    endtask

    // drain all expected posteriors, then let the sequencer settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one configuration setting followed by mostly well-formed samples
    task automatic run_phase(logic [2:0] ni, logic [2:0] nc, logic [2:0] nm, int groups);
        int n, r;
        wait_idle();
        write_reg(llmc_pkg::CfgInputCount, ni);
        write_reg(llmc_pkg::CfgClassCount, nc);
        write_reg(llmc_pkg::CfgComponentCount, nm);
        n = (ni == 3'd0) ? 1 :
            ((int'(ni) > llmc_pkg::MaxInputs) ? llmc_pkg::MaxInputs : int'(ni));
        repeat (groups)
        begin
            r = int'($urandom_range(0, 9));
            if (r < 7)
                send_sample(n);
            else if (r == 7)
                repeat ($urandom_range(1, 4))
                    write_weight(4'($urandom), 2'($urandom), 2'($urandom), rand_weight());
            else if (r == 8)
                send_sample(n + int'($urandom_range(1, 2)));
            else
                send_sample(int'($urandom_range(1, n)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every weight before any sample reads one
        for (int f = 0; f < llmc_pkg::MaxFeatures; f++)
            for (int c = 0; c < llmc_pkg::MaxClasses; c++)
                for (int m = 0; m < llmc_pkg::MaxComponents; m++)
                    write_weight(4'(f), 2'(c), 2'(m), rand_weight());

        // directed: full sample with extremes fills the sample store
        send_element(16'h7fff, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'h0000, 1'b0);
        send_element(16'h0001, 1'b1);
        // all-zero sample
        repeat (3) send_element(16'h0000, 1'b0);
        send_element(16'h0000, 1'b1);
        // out-of-range feature ignored, last flag on a write ignored
        send_item(1'b0, 4'd15, 2'd3, 2'd3, 16'h7fff, 16'h1234, 1'b1);
        write_weight(4'd0, 2'd0, 2'd0, 16'h7fff);
        write_weight(4'd1, 2'd0, 2'd1, 16'h8000);
        write_weight(4'd14, 2'd3, 2'd3, 16'h7fff);
        repeat (3) send_element(16'h7fff, 1'b0);
        send_element(16'h7fff, 1'b1);
        // too many elements, then a short sample
        repeat (6) send_element(rand_sample(), 1'b0);
        send_element(16'h8000, 1'b1);
        send_element(16'h1000, 1'b0);
        send_element(16'hf000, 1'b1);
        // index outside the register set has no effect
        wait_idle();
        write_reg(2'd3, 3'd1);
        send_sample(4);

        // random phases across register settings, extremes included
        run_phase(3'd0, 3'd0, 3'd0, 4);
        run_phase(3'd7, 3'd7, 3'd7, 4);
        run_phase(3'd1, 3'd4, 3'd1, 5);
        run_phase(3'd4, 3'd1, 3'd4, 4);
        run_phase(3'd2, 3'd3, 3'd2, 4);
        run_phase(3'd3, 3'd2, 3'd3, 4);
        run_phase(3'd4, 3'd4, 3'd4, 5);
        run_phase(3'd1, 3'd1, 3'd1, 4);
        run_phase(3'd5, 3'd6, 3'd5, 4);

        wait_idle();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** log_linear_mixture_classifier: PASSED **");
        else
            $display("** log_linear_mixture_classifier: FAILED **");
        $finish;
    end

endmodule
